FILE: design/bmt_pkg.sv
`timescale 1ns / 1ps

package bmt_pkg;

   // Band mixing configuration.
   localparam int BAND_COUNT       = 3;
   localparam int WEIGHT_FRAC_BITS = 12;
   localparam int LANES            = 4;

   // Field widths.
   localparam int PIX_W    = 8;
   localparam int WEIGHT_W = 16;
   localparam int ROW_W    = LANES * WEIGHT_W;
   localparam int CNT_W    = 32;
   localparam int CSR_IDX_W = 8;

   // A weight times a zero-extended pixel, and the sum of four of them plus one half.
   localparam int PROD_W = WEIGHT_W + PIX_W + 1;
   localparam int SUM_W  = PROD_W + 3;

   localparam int PIX_MAX  = 255;
   localparam int PIX_SPAN = 256;

   // Register indexes of the weight rows.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_ROW0 = 8'd0,
      CSR_WEIGHT_ROW1 = 8'd1,
      CSR_WEIGHT_ROW2 = 8'd2,
      CSR_WEIGHT_ROW3 = 8'd3
   } csr_index_type;

   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = CSR_IDX_W'(LANES);

   // Identity matrix after reset: 1.0 on the diagonal.
   localparam logic [ROW_W-1:0] WEIGHT_ROW0_RESET = 64'd4096;
   localparam logic [ROW_W-1:0] WEIGHT_ROW1_RESET = 64'd268435456;
   localparam logic [ROW_W-1:0] WEIGHT_ROW2_RESET = 64'd17592186044416;
   localparam logic [ROW_W-1:0] WEIGHT_ROW3_RESET = 64'd1152921504606846976;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

endpackage

FILE: design/bmt_req_if.sv
`timescale 1ns / 1ps

interface bmt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_band0;
   logic [7:0] pixel_band1;
   logic [7:0] pixel_band2;
   logic [7:0] pixel_band3;

   modport source (output valid, pixel_band0, pixel_band1, pixel_band2, pixel_band3,
                   input ready);
   modport sink   (input valid, pixel_band0, pixel_band1, pixel_band2, pixel_band3,
                   output ready);
endinterface

FILE: design/bmt_rsp_if.sv
`timescale 1ns / 1ps

interface bmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_band0;
   logic [7:0]  out_band1;
   logic [7:0]  out_band2;
   logic [7:0]  out_band3;
   logic [3:0]  overflow_mask;
   logic [3:0]  underflow_mask;
   logic [31:0] overflow_total;
   logic [31:0] underflow_total;

   modport source (output valid, out_band0, out_band1, out_band2, out_band3,
                   overflow_mask, underflow_mask, overflow_total, underflow_total,
                   input ready);
   modport sink   (input valid, out_band0, out_band1, out_band2, out_band3,
                   overflow_mask, underflow_mask, overflow_total, underflow_total,
                   output ready);
endinterface

FILE: design/band_matrix_transform.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Payload
// req_ch    in         valid/ready    pixel_band0..3
// rsp_ch    out        valid/ready    out_band0..3, clamp masks, clamp totals
// csr_*     in         write enable   weight_row0..3 (index 0..3)
//
// One pixel is taken per clock while the pipeline is not stalled; its result passes both stages.
// Stage one registers the sixteen weight-by-pixel products, stage two registers the
// rounded and clamped sums together with the clamp counters.
// Reset clears both valid flags and the counters and loads the identity matrix.
// Each stage holds while the one after it is full and stalled, so one more pixel is
// taken while a finished result waits, and then the input stalls until it moves on.

module band_matrix_transform (
   input  logic                              clock,
   input  logic                              reset,
   bmt_req_if.sink                           req_ch,
   bmt_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_en,
   input  logic [bmt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bmt_pkg::ROW_W-1:0]         csr_data
);
   import bmt_pkg::*;

   localparam sum_type HALF        = SUM_W'(1 << (WEIGHT_FRAC_BITS - 1));
   localparam sum_type OVER_LIMIT  = SUM_W'(PIX_SPAN * (1 << WEIGHT_FRAC_BITS));
   localparam sum_type UNDER_LIMIT = -SUM_W'(1 << WEIGHT_FRAC_BITS);

   logic [ROW_W-1:0]  weight_row_ff [LANES];
   logic [PIX_W-1:0]  pixel         [LANES];

   logic              s1_valid_ff;
   prod_type          s1_prod_in    [LANES][LANES];
   prod_type          s1_prod_ff    [LANES][LANES];

   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  band_in       [LANES];
   logic [PIX_W-1:0]  band_ff       [LANES];
   logic [LANES-1:0]  ovf_mask_in, ovf_mask_ff;
   logic [LANES-1:0]  unf_mask_in, unf_mask_ff;
   logic [CNT_W-1:0]  ovf_count_in, ovf_count_ff;
   logic [CNT_W-1:0]  unf_count_in, unf_count_ff;
   logic [CNT_W:0]    ovf_sum, unf_sum;
   sum_type           band_sum      [LANES];

   logic              s1_load;
   logic              s2_load;

   // Weight rows, written through the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_row_ff[0] <= WEIGHT_ROW0_RESET;
         weight_row_ff[1] <= WEIGHT_ROW1_RESET;
         weight_row_ff[2] <= WEIGHT_ROW2_RESET;
         weight_row_ff[3] <= WEIGHT_ROW3_RESET;
      end else if (csr_write_en && (csr_index < CSR_COUNT)) begin
         weight_row_ff[csr_index[1:0]] <= csr_data;
      end
   end

   // Flow control: each stage loads when it is empty or its contents move on.
   assign s2_load      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s2_load;
   assign s1_load      = req_ch.valid && req_ch.ready;

   assign pixel[0] = req_ch.pixel_band0;
   assign pixel[1] = req_ch.pixel_band1;
   assign pixel[2] = req_ch.pixel_band2;
   assign pixel[3] = req_ch.pixel_band3;

   // Stage one: one product per weight lane; lanes beyond the band count are zero.
   always_comb begin
      for (int b = 0; b < LANES; b++) begin
         for (int i = 0; i < LANES; i++) begin
            if (b < BAND_COUNT && i < BAND_COUNT) begin
               s1_prod_in[b][i] = $signed(weight_row_ff[b][i*WEIGHT_W +: WEIGHT_W])
                                * $signed({1'b0, pixel[i]});
            end else begin
               s1_prod_in[b][i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (s2_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_prod_ff <= s1_prod_in;
      end
   end

   // Stage two: add one half, then truncate the fraction, which rounds to nearest, and clamp each band.
   always_comb begin
      for (int b = 0; b < LANES; b++) begin
         band_sum[b] = HALF + SUM_W'(s1_prod_ff[b][0]) + SUM_W'(s1_prod_ff[b][1])
                            + SUM_W'(s1_prod_ff[b][2]) + SUM_W'(s1_prod_ff[b][3]);
         band_in[b]     = '0;
         ovf_mask_in[b] = 1'b0;
         unf_mask_in[b] = 1'b0;
         if (b < BAND_COUNT) begin
            priority if (band_sum[b] >= OVER_LIMIT) begin
               band_in[b]     = PIX_W'(PIX_MAX);
               ovf_mask_in[b] = 1'b1;
            end else if (band_sum[b] <= UNDER_LIMIT) begin
               unf_mask_in[b] = 1'b1;
            end else if (band_sum[b] >= 0) begin
               band_in[b] = band_sum[b][WEIGHT_FRAC_BITS +: PIX_W];
            end else begin
               band_in[b] = '0;
            end
         end
      end
   end

   // Saturating clamp counters; one count for each clamped band.
   always_comb begin
      ovf_sum      = {1'b0, ovf_count_ff} + (CNT_W + 1)'($countones(ovf_mask_in));
      unf_sum      = {1'b0, unf_count_ff} + (CNT_W + 1)'($countones(unf_mask_in));
      ovf_count_in = ovf_sum[CNT_W] ? '1 : ovf_sum[CNT_W-1:0];
      unf_count_in = unf_sum[CNT_W] ? '1 : unf_sum[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ovf_count_ff <= '0;
         unf_count_ff <= '0;
      end else begin
         if (s2_load) begin
            rsp_valid_ff <= 1'b1;
            ovf_count_ff <= ovf_count_in;
            unf_count_ff <= unf_count_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         band_ff     <= band_in;
         ovf_mask_ff <= ovf_mask_in;
         unf_mask_ff <= unf_mask_in;
      end
   end

   // Result channel.
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.out_band0       = band_ff[0];
   assign rsp_ch.out_band1       = band_ff[1];
   assign rsp_ch.out_band2       = band_ff[2];
   assign rsp_ch.out_band3       = band_ff[3];
   assign rsp_ch.overflow_mask   = ovf_mask_ff;
   assign rsp_ch.underflow_mask  = unf_mask_ff;
   assign rsp_ch.overflow_total  = ovf_count_ff;
   assign rsp_ch.underflow_total = unf_count_ff;

`ifndef SYNTHESIS
   // A band cannot be clamped both ways in the same transfer.
   a_mask_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((ovf_mask_ff & unf_mask_ff) == '0))
      else $error("overflow and underflow flagged on the same band");

   // An overflowed band zero always reads full scale.
   a_ovf_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ovf_mask_ff[0]) |-> (band_ff[0] == PIX_W'(PIX_MAX)))
      else $error("overflowed band is not full scale");

   // Counters never go backwards.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> (ovf_count_ff >= $past(ovf_count_ff))
                  && (unf_count_ff >= $past(unf_count_ff)))
      else $error("clamp counter went backwards");

   // The overflow count grows by the number of flagged bands unless saturated.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> (ovf_count_ff == ($past(ovf_count_ff)
                                    + CNT_W'($countones(ovf_mask_ff))))
                  || (ovf_count_ff == '1))
      else $error("overflow count does not match the flagged bands");
`endif

endmodule

FILE: tb/sv/bmt_mix_checker.sv
`timescale 1ns / 1ps

// Watches the pixel and result channels and the register port, predicts each
// result from its own copy of the weights and clamp counters, and compares
// every result transfer field by field with the oldest prediction.
module bmt_mix_checker (
   input  logic                          clock,
   input  logic                          reset,
   bmt_req_if                            pixel_ch,
   bmt_rsp_if                            mix_ch,
   input  logic                          csr_write_en,
   input  logic [bmt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bmt_pkg::ROW_W-1:0]     csr_data,
   output int                            mismatch_count,
   output int                            pixels_outstanding
);
   import bmt_pkg::*;

   typedef struct {
      logic [PIX_W-1:0] band [LANES];
      logic [LANES-1:0] overflow_mask;
      logic [LANES-1:0] underflow_mask;
      logic [CNT_W-1:0] overflow_total;
      logic [CNT_W-1:0] underflow_total;
   } mixed_pixel_type;

   logic [ROW_W-1:0] weight_row [LANES];
   logic [CNT_W-1:0] overflow_clamps;
   logic [CNT_W-1:0] underflow_clamps;
   mixed_pixel_type  expected_mix_q [$];
   int               results_seen;

   task automatic note_failure(input string detail);
      $display("MISMATCH at %0t: %s", $realtime, detail);
      mismatch_count++;
   endtask

   // Mixes one pixel with the current weights and advances the clamp counters.
   function automatic mixed_pixel_type mix_pixel(input logic [PIX_W-1:0] pix [LANES]);
      mixed_pixel_type mixed;
      longint          one_lsb;
      longint          acc;
      one_lsb = longint'(1) << WEIGHT_FRAC_BITS;
      mixed.overflow_mask  = '0;
      mixed.underflow_mask = '0;
      for (int b = 0; b < LANES; b++) begin
         mixed.band[b] = '0;
         if (b < BAND_COUNT) begin
            // Exact sum plus one half; lanes of inactive bands play no part.
            acc = one_lsb >>> 1;
            for (int i = 0; i < BAND_COUNT && i < LANES; i++) begin
               acc += longint'($signed(weight_row[b][WEIGHT_W*i +: WEIGHT_W]))
                      * longint'(pix[i]);
            end
            if (acc >= PIX_SPAN * one_lsb) begin
               mixed.band[b]          = PIX_W'(PIX_MAX);
               mixed.overflow_mask[b] = 1'b1;
               if (overflow_clamps != '1) overflow_clamps++;
            end else if (acc <= -one_lsb) begin
               mixed.underflow_mask[b] = 1'b1;
               if (underflow_clamps != '1) underflow_clamps++;
            end else if (acc >= 0) begin
               mixed.band[b] = PIX_W'(acc >>> WEIGHT_FRAC_BITS);
            end
            // A small negative sum truncates towards zero and is no underflow.
         end
      end
      mixed.overflow_total  = overflow_clamps;
      mixed.underflow_total = underflow_clamps;
      return mixed;
   endfunction

   always @(posedge clock) begin
      logic [PIX_W-1:0] pix [LANES];
      mixed_pixel_type  got;
      mixed_pixel_type  want;
      if (reset) begin
         weight_row[0]    = WEIGHT_ROW0_RESET;
         weight_row[1]    = WEIGHT_ROW1_RESET;
         weight_row[2]    = WEIGHT_ROW2_RESET;
         weight_row[3]    = WEIGHT_ROW3_RESET;
         overflow_clamps  = '0;
         underflow_clamps = '0;
         mismatch_count   = 0;
         results_seen     = 0;
         expected_mix_q.delete();
      end else begin
         // Writes to an index beyond the weight rows are dropped.
         if (csr_write_en && csr_index < CSR_COUNT) begin
            weight_row[csr_index[1:0]] = csr_data;
         end

         if (pixel_ch.valid && pixel_ch.ready) begin
            pix[0] = pixel_ch.pixel_band0;
            pix[1] = pixel_ch.pixel_band1;
            pix[2] = pixel_ch.pixel_band2;
            pix[3] = pixel_ch.pixel_band3;
            expected_mix_q.push_back(mix_pixel(pix));
         end

         // Compare a result transfer with the oldest prediction.
         if (mix_ch.valid && mix_ch.ready) begin
            got.band[0]         = mix_ch.out_band0;
            got.band[1]         = mix_ch.out_band1;
            got.band[2]         = mix_ch.out_band2;
            got.band[3]         = mix_ch.out_band3;
            got.overflow_mask   = mix_ch.overflow_mask;
            got.underflow_mask  = mix_ch.underflow_mask;
            got.overflow_total  = mix_ch.overflow_total;
            got.underflow_total = mix_ch.underflow_total;
            if (expected_mix_q.size() == 0) begin
               note_failure($sformatf("result %0d arrived with no pixel outstanding",
                                      results_seen));
            end else begin
               want = expected_mix_q.pop_front();
               for (int b = 0; b < LANES; b++) begin
                  if (got.band[b] !== want.band[b]) begin
                     note_failure($sformatf("result %0d out_band%0d: got %0d, expected %0d",
                                            results_seen, b, got.band[b], want.band[b]));
                  end
               end
               if (got.overflow_mask !== want.overflow_mask) begin
                  note_failure($sformatf("result %0d overflow_mask: got %b, expected %b",
                                         results_seen, got.overflow_mask,
                                         want.overflow_mask));
               end
               if (got.underflow_mask !== want.underflow_mask) begin
                  note_failure($sformatf("result %0d underflow_mask: got %b, expected %b",
                                         results_seen, got.underflow_mask,
                                         want.underflow_mask));
               end
               if (got.overflow_total !== want.overflow_total) begin
                  note_failure($sformatf("result %0d overflow_total: got %0d, expected %0d",
                                         results_seen, got.overflow_total,
                                         want.overflow_total));
               end
               if (got.underflow_total !== want.underflow_total) begin
                  note_failure($sformatf("result %0d underflow_total: got %0d, expected %0d",
                                         results_seen, got.underflow_total,
                                         want.underflow_total));
               end
            end
            results_seen++;
         end
      end
      pixels_outstanding <= expected_mix_q.size();
   end

endmodule

FILE: tb/sv/tb_band_matrix_transform.sv
`timescale 1ns / 1ps

module tb_band_matrix_transform;
   import bmt_pkg::*;

   localparam int RESET_CYCLES     = 5;
   localparam int BLOCK_PIXELS     = 130;
   localparam int BLOCKS_PER_PHASE = 5;
   localparam int HOLDOFF_CYCLES   = 200;
   localparam int DRAIN_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT   = 2000;

   localparam logic [WEIGHT_W-1:0] UNIT_WEIGHT = WEIGHT_W'(1 << WEIGHT_FRAC_BITS);

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ROW_W-1:0]     csr_data;
   logic                 holdoff_toggle;
   int                   send_gap_pct;
   int                   recv_gap_pct;
   int                   mismatch_count;
   int                   pixels_outstanding;
   int                   quiet_cycles;

   bmt_req_if pixel_in ();
   bmt_rsp_if mix_out ();

   always #5 clock = ~clock;

   band_matrix_transform i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (pixel_in),
      .rsp_ch       (mix_out),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   bmt_mix_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .pixel_ch           (pixel_in),
      .mix_ch             (mix_out),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .pixels_outstanding (pixels_outstanding)
   );

   // Pixel values lean towards the extremes now and then.
   function automatic logic [PIX_W-1:0] pick_pixel();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return PIX_W'(PIX_MAX);
      return PIX_W'($urandom_range(0, PIX_MAX));
   endfunction

   // Mostly weights within plus or minus one, so that many sums stay in range.
   function automatic logic [ROW_W-1:0] pick_weight_row(input int band);
      logic [ROW_W-1:0] row;
      int               roll;
      row  = '0;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         for (int i = 0; i < LANES; i++) begin
            row[WEIGHT_W*i +: WEIGHT_W] = WEIGHT_W'($urandom_range(0, 8192) - 4096);
         end
      end else if (roll < 75) begin
         row = {$urandom, $urandom};
      end else if (roll < 85) begin
         row[WEIGHT_W*band +: WEIGHT_W] = UNIT_WEIGHT;
      end else if (roll < 90) begin
         row = '0;
      end else if (roll < 95) begin
         row = {LANES{16'h7FFF}};
      end else begin
         row = {LANES{16'h8000}};
      end
      return row;
   endfunction

   // Offers one pixel after a random gap and returns at the edge of its transfer.
   task automatic send_pixel(input logic [PIX_W-1:0] p0, p1, p2, p3);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         pixel_in.valid <= 1'b0;
         @(posedge clock);
      end
      pixel_in.valid       <= 1'b1;
      pixel_in.pixel_band0 <= p0;
      pixel_in.pixel_band1 <= p1;
      pixel_in.pixel_band2 <= p2;
      pixel_in.pixel_band3 <= p3;
      do @(posedge clock); while (!pixel_in.ready);
   endtask

   task automatic send_random_pixels(input int count);
      repeat (count) send_pixel(pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel());
   endtask

   // Stops offering pixels until every predicted result has arrived.
   task automatic wait_drained();
      pixel_in.valid <= 1'b0;
      do @(posedge clock); while (pixels_outstanding != 0);
   endtask

   // Writes all four weight rows, then a write to an unused index that must be dropped.
   task automatic write_weights(input logic [ROW_W-1:0] row0, row1, row2, row3);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_WEIGHT_ROW0;
      csr_data     <= row0;
      @(posedge clock);
      csr_index    <= CSR_WEIGHT_ROW1;
      csr_data     <= row1;
      @(posedge clock);
      csr_index    <= CSR_WEIGHT_ROW2;
      csr_data     <= row2;
      @(posedge clock);
      csr_index    <= CSR_WEIGHT_ROW3;
      csr_data     <= row3;
      @(posedge clock);
      csr_index    <= CSR_COUNT + CSR_IDX_W'($urandom_range(0, 251));
      csr_data     <= {$urandom, $urandom};
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // The receiver stalls at random, or for a long stretch whenever the toggle flips.
   initial begin
      int   holdoff_left;
      logic holdoff_seen;
      holdoff_left  = 0;
      holdoff_seen  = 1'b0;
      mix_out.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_toggle !== holdoff_seen) begin
            holdoff_seen = holdoff_toggle;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            mix_out.ready <= 1'b0;
         end else begin
            mix_out.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
         end
      end
   end

   // Ends the run when no transfer has happened on either channel for too long.
   always @(posedge clock) begin
      if (reset || (pixel_in.valid && pixel_in.ready) || (mix_out.valid && mix_out.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                <= 1'b1;
      csr_write_en         <= 1'b0;
      csr_index            <= CSR_WEIGHT_ROW0;
      csr_data             <= '0;
      holdoff_toggle       <= 1'b0;
      pixel_in.valid       <= 1'b0;
      pixel_in.pixel_band0 <= '0;
      pixel_in.pixel_band1 <= '0;
      pixel_in.pixel_band2 <= '0;
      pixel_in.pixel_band3 <= '0;
      send_gap_pct         = 27;
      recv_gap_pct         = 69;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Identity matrix out of reset: bands pass through, band three reads as zero.
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
      send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
      send_pixel(8'h01, 8'h02, 8'h03, 8'h04);

      // Minus one half on band zero probes rounding of negatives; weights just
      // above one probe the overflow boundary; row three only feeds an idle band.
      wait_drained();
      write_weights({48'h0, 16'hF800}, {48'h0, 16'h1009}, {48'h0, 16'h1008}, '1);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd1, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd2, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd3, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd254, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255);

      // Largest positive weights, then largest negative: several clamps per pixel.
      wait_drained();
      write_weights({LANES{16'h7FFF}}, {LANES{16'h7FFF}}, {LANES{16'h7FFF}},
                    {LANES{16'h7FFF}});
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
      wait_drained();
      write_weights({LANES{16'h8000}}, {LANES{16'h8000}}, {LANES{16'h8000}},
                    {LANES{16'h8000}});
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd255);

      // Random pixels under random weights, in three idling regimes.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 27;
               recv_gap_pct = 69;
            end
            1: begin
               send_gap_pct = 69;
               recv_gap_pct = 27;
            end
            default: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
            end
         endcase
         for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
            wait_drained();
            write_weights(pick_weight_row(0), pick_weight_row(1), pick_weight_row(2),
                          pick_weight_row(3));
            // A long receiver stall while pixels keep coming fills the pipeline.
            if (blk == 0 && phase < 2) holdoff_toggle <= ~holdoff_toggle;
            send_random_pixels(BLOCK_PIXELS);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
